// ===== design/ipsai_pkg.sv =====
// Shared types and constants for the IPv4 source address inference block.
// Depends on nothing; imported by the controller, the datapath and the top level.
`default_nettype none

package ipsai_pkg;

    typedef enum logic [1:0] {
        OP_CLEAR    = 2'd0,
        OP_APPEND   = 2'd1,
        OP_RESOLVE  = 2'd2,
        OP_CLASSIFY = 2'd3
    } t_opcode;

    // 127.0.0.1 with the first octet in bits 7:0
    localparam logic [31:0] LOOPBACK_ADDR = 32'h0100_007F;

    // private ranges, compared in network order (first octet in bits 31:24)
    localparam logic [31:0] PRIV_A_MASK = 32'hff00_0000;
    localparam logic [31:0] PRIV_A_NET  = 32'h0a00_0000;
    localparam logic [31:0] PRIV_B_MASK = 32'hfff0_0000;
    localparam logic [31:0] PRIV_B_NET  = 32'hac10_0000;
    localparam logic [31:0] PRIV_C_MASK = 32'hffff_0000;
    localparam logic [31:0] PRIV_C_NET  = 32'hc0a8_0000;

    // controller to datapath
    typedef struct packed {
        logic load;    // capture the input word, update the table
        logic rd_en;   // read the next table entry
        logic finish;  // load the result register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic scan_req;  // input word needs a table scan
        logic last_idx;  // the read being issued is the last valid entry
        logic out_free;  // result register can take a new result
    } t_sts;

    function automatic logic is_private(input logic [31:0] addr);
        logic [31:0] be;
        be = {addr[7:0], addr[15:8], addr[23:16], addr[31:24]};
        return ((be & PRIV_A_MASK) == PRIV_A_NET) ||
               ((be & PRIV_B_MASK) == PRIV_B_NET) ||
               ((be & PRIV_C_MASK) == PRIV_C_NET);
    endfunction

endpackage

`default_nettype wire

// ===== design/ipsai_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ipsai_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== design/ipsai_ctrl.sv =====
// Sequencing state machine: accept, scan the table, drain the read, post the result.
// Depends on ipsai_pkg.
`default_nettype none

module ipsai_ctrl
    import ipsai_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FIN
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_sts.scan_req ? S_SCAN : S_FIN;
                end
            end
            S_SCAN: begin
                o_cmd.rd_en = 1'b1;
                if (i_sts.last_idx) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready = (r_state == S_IDLE);

endmodule

`default_nettype wire

// ===== design/ipsai_dp.sv =====
// Datapath: interface table, priority scan registers and the result register.
// Depends on ipsai_pkg and ipsai_ram.
`default_nettype none

module ipsai_dp
    import ipsai_pkg::*;
#(
    parameter int MAX_INTERFACES = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmd        i_cmd,
    output t_sts             o_sts,
    input  wire logic [1:0]  i_opcode,
    input  wire logic [31:0] i_entry_address,
    input  wire logic [31:0] i_entry_netmask,
    input  wire logic [31:0] i_src_addr,
    input  wire logic [31:0] i_dst_addr,
    input  wire logic [15:0] i_src_port,
    input  wire logic [15:0] i_dst_port,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [31:0]      o_new_src_addr,
    output logic [31:0]      o_new_dst_addr,
    output logic             o_tuple_changed,
    output logic             o_private_or_on_subnet,
    output logic             o_is_interface_addr,
    output logic             o_status
);

    localparam int IDX_W = (MAX_INTERFACES > 1) ? $clog2(MAX_INTERFACES) : 1;
    localparam int CNT_W = $clog2(MAX_INTERFACES + 1);

    t_opcode           in_op;
    logic [CNT_W-1:0]  r_count;
    logic              table_full;
    logic              do_append;

    t_opcode           r_op;
    logic [31:0]       r_src, r_dst, r_other;
    logic [15:0]       r_sport, r_dport;
    logic              r_drop;

    logic [IDX_W-1:0]  r_idx;
    logic              r_rd_vld;
    logic [63:0]       rd_data;
    logic [31:0]       ent_addr, ent_mask;

    logic              r_hit_exact, r_hit_subnet, r_hit_nonlb;
    logic [31:0]       r_addr_subnet, r_addr_nonlb;
    logic              m_exact, m_subnet, m_nonlb;

    logic [31:0]       fill;
    logic              same_src, same_dst;

    assign in_op      = t_opcode'(i_opcode);
    assign table_full = (r_count == CNT_W'(MAX_INTERFACES));
    assign do_append  = i_cmd.load && (in_op == OP_APPEND) && !table_full;

    ipsai_ram #(
        .WIDTH (64),
        .DEPTH (MAX_INTERFACES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (do_append),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata ({i_entry_netmask, i_entry_address}),
        .i_re    (i_cmd.rd_en),
        .i_raddr (r_idx),
        .o_rdata (rd_data)
    );

    assign ent_addr = rd_data[31:0];
    assign ent_mask = rd_data[63:32];
    assign m_exact  = (ent_addr == r_other);
    assign m_subnet = ((ent_addr & ent_mask) == (r_other & ent_mask));
    assign m_nonlb  = (ent_addr != LOOPBACK_ADDR);

    assign o_sts.scan_req = ((in_op == OP_RESOLVE) || (in_op == OP_CLASSIFY)) &&
                            (r_count != '0);
    assign o_sts.last_idx = ((CNT_W'(r_idx) + CNT_W'(1)) == r_count);
    assign o_sts.out_free = !o_valid || i_ready;

    // control: table fill, scan pointer, read pipeline, result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_idx    <= '0;
            r_rd_vld <= 1'b0;
            o_valid  <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.rd_en;
            if (i_cmd.load) begin
                r_idx <= '0;
                if (in_op == OP_CLEAR) begin
                    r_count <= '0;
                end else if (do_append) begin
                    r_count <= r_count + CNT_W'(1);
                end
            end else if (i_cmd.rd_en) begin
                r_idx <= r_idx + IDX_W'(1);
            end
            if (i_cmd.finish) begin
                o_valid <= 1'b1;
            end else if (i_ready) begin
                o_valid <= 1'b0;
            end
        end
    end

    // payload: captured word, first-hit registers, result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op         <= in_op;
            r_src        <= i_src_addr;
            r_dst        <= i_dst_addr;
            r_sport      <= i_src_port;
            r_dport      <= i_dst_port;
            r_other      <= ((in_op == OP_RESOLVE) && (i_src_addr != '0)) ?
                            i_src_addr : i_dst_addr;
            r_drop       <= (in_op == OP_APPEND) && table_full;
            r_hit_exact  <= 1'b0;
            r_hit_subnet <= 1'b0;
            r_hit_nonlb  <= 1'b0;
        end else if (r_rd_vld) begin
            // keep only the first hit of each kind
            if (!r_hit_exact && m_exact) begin
                r_hit_exact <= 1'b1;
            end
            if (!r_hit_subnet && m_subnet) begin
                r_hit_subnet  <= 1'b1;
                r_addr_subnet <= ent_addr;
            end
            if (!r_hit_nonlb && m_nonlb) begin
                r_hit_nonlb  <= 1'b1;
                r_addr_nonlb <= ent_addr;
            end
        end
        if (i_cmd.finish) begin
            o_new_src_addr         <= r_src;
            o_new_dst_addr         <= r_dst;
            o_tuple_changed        <= 1'b0;
            o_private_or_on_subnet <= 1'b0;
            o_is_interface_addr    <= 1'b0;
            o_status               <= r_drop;
            if (r_op == OP_RESOLVE) begin
                if (r_src == '0) begin
                    o_new_src_addr  <= same_dst ? r_src : fill;
                    o_tuple_changed <= !same_dst;
                end else if (r_dst == '0) begin
                    o_new_dst_addr  <= same_src ? r_dst : fill;
                    o_tuple_changed <= !same_src;
                end
            end else if (r_op == OP_CLASSIFY) begin
                o_private_or_on_subnet <= is_private(r_dst) || r_hit_subnet;
                o_is_interface_addr    <= r_hit_exact;
            end
        end
    end

    // an exact hit returns the other address itself
    assign fill = r_hit_exact  ? r_other :
                  r_hit_subnet ? r_addr_subnet :
                  r_hit_nonlb  ? r_addr_nonlb : 32'd0;

    assign same_dst = (fill == r_dst) && (r_sport == r_dport);
    assign same_src = (fill == r_src) && (r_sport == r_dport);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_INTERFACES))
        else $error("entry count beyond table depth");

    a_read_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd_en |-> (CNT_W'(r_idx) < r_count))
        else $error("table read past last valid entry");

    a_finish_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> o_valid)
        else $error("result not posted after finish");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |-> (!o_valid || i_ready))
        else $error("result register overwritten while held");

    a_result_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_private_or_on_subnet || o_is_interface_addr)) |->
        (!o_tuple_changed && !o_status))
        else $error("classify flags mixed with another result kind");

endmodule

`default_nettype wire

// ===== design/ipv4_source_address_inference.sv =====
// Top level of the IPv4 source address inference block.
// Depends on ipsai_pkg, ipsai_ctrl, ipsai_dp (which holds ipsai_ram).
//
// Usage:
//   Input channel i_valid/o_ready carries one word: an opcode plus the entry,
//   tuple and port fields. Output channel o_valid/i_ready returns exactly one
//   result word for every input word, in order.
//   Opcodes: clear the interface table, append an address/netmask pair
//   (dropped with o_status set when the table already holds MAX_INTERFACES
//   entries), resolve a socket tuple with a zero address, classify i_dst_addr.
//   Resolve and classify scan a table of N entries (0 to MAX_INTERFACES):
//   one entry is read per cycle, in priority order, and each read updates
//   the first exact, first on-subnet and first non-loopback hits. Clear and
//   append, and resolve or classify with N = 0, skip the scan; after a scan,
//   a drain state waits for the registered last read before the result.
//   One word is in work at a time; o_ready is high while the block is idle.
//   The result register sits between the sides: a new word is accepted while
//   a result still waits, and that word waits in the datapath's capture and
//   hit registers until the receiver takes the previous one. A stalled
//   receiver never loses or repeats a result.
//   Reset: i_rst_n low at a rising edge empties the table and drops any word
//   in work or pending result. No clearing pass is needed afterwards.
`default_nettype none

module ipv4_source_address_inference
    import ipsai_pkg::*;
#(
    parameter int MAX_INTERFACES = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_opcode,
    input  wire logic [31:0] i_entry_address,
    input  wire logic [31:0] i_entry_netmask,
    input  wire logic [31:0] i_src_addr,
    input  wire logic [31:0] i_dst_addr,
    input  wire logic [15:0] i_src_port,
    input  wire logic [15:0] i_dst_port,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [31:0]      o_new_src_addr,
    output logic [31:0]      o_new_dst_addr,
    output logic             o_tuple_changed,
    output logic             o_private_or_on_subnet,
    output logic             o_is_interface_addr,
    output logic             o_status
);

    t_cmd cmd;
    t_sts sts;

    // sequencing: accept, scan, drain the last read, post the result
    ipsai_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // table, scan hit registers and result register
    ipsai_dp #(
        .MAX_INTERFACES (MAX_INTERFACES)
    ) u_dp (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cmd                  (cmd),
        .o_sts                  (sts),
        .i_opcode               (i_opcode),
        .i_entry_address        (i_entry_address),
        .i_entry_netmask        (i_entry_netmask),
        .i_src_addr             (i_src_addr),
        .i_dst_addr             (i_dst_addr),
        .i_src_port             (i_src_port),
        .i_dst_port             (i_dst_port),
        .o_valid                (o_valid),
        .i_ready                (i_ready),
        .o_new_src_addr         (o_new_src_addr),
        .o_new_dst_addr         (o_new_dst_addr),
        .o_tuple_changed        (o_tuple_changed),
        .o_private_or_on_subnet (o_private_or_on_subnet),
        .o_is_interface_addr    (o_is_interface_addr),
        .o_status               (o_status)
    );

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking bench for ipv4_source_address_inference: table upkeep, tuple resolve, classify.
// Predicts every result word in a scoreboard class and drives both valid/ready channels at random.
// Depends on ipsai_pkg and the block's RTL only.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ipsai_pkg::*;

    localparam int          TABLE_DEPTH  = 16;
    localparam int unsigned RANDOM_ITEMS = 700;
    localparam int unsigned LONG_HOLD    = 300;
    localparam int unsigned DRAIN_CYCLES = 40;
    localparam int unsigned CYCLE_LIMIT  = 200_000;
    localparam logic [31:0] LOOPBACK     = 32'h0100_007F;  // 127.0.0.1, first octet low

    // one input word and one result word, field for field
    typedef struct packed {
        t_opcode     op;
        logic [31:0] entry_address;
        logic [31:0] entry_netmask;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] src_port;
        logic [15:0] dst_port;
    } t_request;

    typedef struct packed {
        logic [31:0] new_src;
        logic [31:0] new_dst;
        logic        changed;
        logic        private_or_subnet;
        logic        is_iface;
        logic        status;
    } t_reply;

    // Scoreboard: mirrors the interface table, predicts one reply per accepted
    // request and checks replies against the oldest prediction.
    class inference_checker;
        logic [31:0] if_addr [TABLE_DEPTH];
        logic [31:0] if_mask [TABLE_DEPTH];
        int unsigned n_entries;
        int unsigned n_errors;
        t_reply      pending_replies [$];

        function new();
            n_entries = 0;
            n_errors  = 0;
        endfunction

        // first exact hit, else first on-subnet hit, else first non-loopback entry
        function logic [31:0] pick_fill(input logic [31:0] other);
            for (int i = 0; i < n_entries; i++)
                if (if_addr[i] == other) return if_addr[i];
            for (int i = 0; i < n_entries; i++)
                if ((if_addr[i] & if_mask[i]) == (other & if_mask[i])) return if_addr[i];
            for (int i = 0; i < n_entries; i++)
                if (if_addr[i] != LOOPBACK) return if_addr[i];
            return 32'h0;
        endfunction

        // 10/8, 192.168/16, 172.16/12, read octet by octet
        function bit in_private_block(input logic [31:0] a);
            return (a[7:0] == 8'd10) ||
                   (a[7:0] == 8'd192 && a[15:8] == 8'd168) ||
                   (a[7:0] == 8'd172 && a[15:12] == 4'h1);
        endfunction

        function bit on_any_subnet(input logic [31:0] a);
            for (int i = 0; i < n_entries; i++)
                if ((if_addr[i] & if_mask[i]) == (a & if_mask[i])) return 1'b1;
            return 1'b0;
        endfunction

        function bit is_table_addr(input logic [31:0] a);
            for (int i = 0; i < n_entries; i++)
                if (if_addr[i] == a) return 1'b1;
            return 1'b0;
        endfunction

        function void note_request(input t_request rq);
            t_reply      rp;
            logic [31:0] fill;
            rp = '0;
            rp.new_src = rq.src_addr;
            rp.new_dst = rq.dst_addr;
            case (rq.op)
                OP_CLEAR: begin
                    n_entries = 0;
                end
                OP_APPEND: begin
                    if (n_entries < TABLE_DEPTH) begin
                        if_addr[n_entries] = rq.entry_address;
                        if_mask[n_entries] = rq.entry_netmask;
                        n_entries++;
                    end else begin
                        rp.status = 1'b1;
                    end
                end
                OP_RESOLVE: begin
                    if (rq.src_addr == 32'h0) begin
                        fill = pick_fill(rq.dst_addr);
                        if (!(fill == rq.dst_addr && rq.src_port == rq.dst_port)) begin
                            rp.new_src = fill;
                            rp.changed = 1'b1;
                        end
                    end else if (rq.dst_addr == 32'h0) begin
                        fill = pick_fill(rq.src_addr);
                        if (!(fill == rq.src_addr && rq.src_port == rq.dst_port)) begin
                            rp.new_dst = fill;
                            rp.changed = 1'b1;
                        end
                    end
                end
                default: begin
                    rp.private_or_subnet = in_private_block(rq.dst_addr) ||
                                           on_any_subnet(rq.dst_addr);
                    rp.is_iface = is_table_addr(rq.dst_addr);
                end
            endcase
            pending_replies = {pending_replies, rp};
        endfunction

        function void compare(input string field, input logic [31:0] want,
                              input logic [31:0] got);
            if (want !== got) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("[%0t] mismatch on %s: expected %h, got %h",
                             $time, field, want, got);
            end
        endfunction

        function void check_reply(input t_reply got);
            t_reply want;
            if (pending_replies.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("[%0t] result word with nothing pending: %h", $time, got);
                return;
            end
            want = pending_replies.pop_front();
            compare("new_src_addr", want.new_src, got.new_src);
            compare("new_dst_addr", want.new_dst, got.new_dst);
            compare("tuple_changed", want.changed, got.changed);
            compare("private_or_on_subnet", want.private_or_subnet, got.private_or_subnet);
            compare("is_interface_addr", want.is_iface, got.is_iface);
            compare("status", want.status, got.status);
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_opcode;
    logic [31:0] i_entry_address;
    logic [31:0] i_entry_netmask;
    logic [31:0] i_src_addr;
    logic [31:0] i_dst_addr;
    logic [15:0] i_src_port;
    logic [15:0] i_dst_port;
    logic        o_valid;
    logic        i_ready;
    logic [31:0] o_new_src_addr;
    logic [31:0] o_new_dst_addr;
    logic        o_tuple_changed;
    logic        o_private_or_on_subnet;
    logic        o_is_interface_addr;
    logic        o_status;

    inference_checker chk;
    int unsigned      n_sent = 0;
    int unsigned      send_calm = 0;   // remaining words the sender offers back to back
    int unsigned      take_calm = 0;   // remaining words the receiver takes back to back
    int unsigned      cycle_count = 0;

    ipv4_source_address_inference #(
        .MAX_INTERFACES(TABLE_DEPTH)
    ) i_dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_valid               (i_valid),
        .o_ready               (o_ready),
        .i_opcode              (i_opcode),
        .i_entry_address       (i_entry_address),
        .i_entry_netmask       (i_entry_netmask),
        .i_src_addr            (i_src_addr),
        .i_dst_addr            (i_dst_addr),
        .i_src_port            (i_src_port),
        .i_dst_port            (i_dst_port),
        .o_valid               (o_valid),
        .i_ready               (i_ready),
        .o_new_src_addr        (o_new_src_addr),
        .o_new_dst_addr        (o_new_dst_addr),
        .o_tuple_changed       (o_tuple_changed),
        .o_private_or_on_subnet(o_private_or_on_subnet),
        .o_is_interface_addr   (o_is_interface_addr),
        .o_status              (o_status)
    );

    // 12 ns clock
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // watchdog: end the run with a failure once the cycle count reaches CYCLE_LIMIT
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // dotted-quad address, first octet lands in bits 7:0
    function automatic logic [31:0] ip(input int unsigned a, input int unsigned b,
                                       input int unsigned c, input int unsigned d);
        return {d[7:0], c[7:0], b[7:0], a[7:0]};
    endfunction

    // Idle cycles before the next word: mostly drawn at random, with runs of zero
    // so that back-to-back traffic shows up as well.
    function automatic int unsigned pick_wait(inout int unsigned calm);
        if (calm != 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0) begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 8);
    endfunction

    // Netmask in wire order: mostly proper prefixes, sometimes anything.
    function automatic logic [31:0] pick_mask();
        logic [31:0] prefix;
        prefix = 32'hffff_ffff << (32 - $urandom_range(0, 32));
        case ($urandom_range(0, 5))
            0:       return $urandom;
            1:       return 32'hffff_ffff;
            default: return {prefix[7:0], prefix[15:8], prefix[23:16], prefix[31:24]};
        endcase
    endfunction

    // Address biased toward the table contents, their subnets, loopback,
    // the private blocks and their edges; plain random otherwise.
    function automatic logic [31:0] pick_addr();
        int unsigned k;
        logic [31:0] a;
        logic [31:0] m;
        k = (chk.n_entries == 0) ? 0 : $urandom_range(0, chk.n_entries - 1);
        a = chk.if_addr[k];
        m = chk.if_mask[k];
        case ($urandom_range(0, 9))
            0: return 32'h0;
            1, 2: if (chk.n_entries != 0) return a;
            3, 4: if (chk.n_entries != 0) return (a & m) | ($urandom & ~m);
            5: return LOOPBACK;
            6: begin
                case ($urandom_range(0, 3))
                    0: return ip(10, $urandom, $urandom, $urandom);
                    1: return ip(192, 168, $urandom, $urandom);
                    2: return ip(172, $urandom_range(15, 32), $urandom, $urandom);
                    default: return ip(192, $urandom_range(167, 169), $urandom, $urandom);
                endcase
            end
            default: ;
        endcase
        return $urandom;
    endfunction

    // every field random; the opcode decides which ones matter
    function automatic t_request base_request(input t_opcode op);
        t_request rq;
        rq.op            = op;
        rq.entry_address = $urandom;
        rq.entry_netmask = $urandom;
        rq.src_addr      = $urandom;
        rq.dst_addr      = $urandom;
        rq.src_port      = $urandom_range(0, 65535);
        rq.dst_port      = $urandom_range(0, 65535);
        return rq;
    endfunction

    function automatic t_request make_request(input t_opcode op);
        t_request rq;
        rq = base_request(op);
        case (op)
            OP_APPEND: begin
                rq.entry_address = ($urandom_range(0, 3) == 0) ? LOOPBACK : pick_addr();
                rq.entry_netmask = pick_mask();
            end
            OP_RESOLVE: begin
                rq.src_addr = pick_addr();
                rq.dst_addr = pick_addr();
                case ($urandom_range(0, 7))
                    0:       begin rq.src_addr = 32'h0; rq.dst_addr = 32'h0; end
                    1, 2, 3: rq.src_addr = 32'h0;
                    4, 5, 6: rq.dst_addr = 32'h0;
                    default: ;
                endcase
                // equal ports open the "fill equals other side" skip
                if ($urandom_range(0, 9) < 4) rq.dst_port = rq.src_port;
            end
            OP_CLASSIFY: begin
                rq.dst_addr = pick_addr();
            end
            default: ;
        endcase
        return rq;
    endfunction

    // Offer one word and hold it until the block takes it, then note it.
    task automatic send_request(input t_request rq);
        int unsigned gap;
        gap = pick_wait(send_calm);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_opcode        <= rq.op;
        i_entry_address <= rq.entry_address;
        i_entry_netmask <= rq.entry_netmask;
        i_src_addr      <= rq.src_addr;
        i_dst_addr      <= rq.dst_addr;
        i_src_port      <= rq.src_port;
        i_dst_port      <= rq.dst_port;
        do @(posedge i_clk); while (!o_ready);
        chk.note_request(rq);
        n_sent++;
    endtask

    // Result side: stall at random, hold off long twice so the block backs up,
    // check every word taken.
    initial begin : reply_sink
        int unsigned hold;
        int unsigned taken;
        t_reply      got;
        taken = 0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            hold = pick_wait(take_calm);
            if (taken == 120 || taken == 480) hold = LONG_HOLD;
            if (hold != 0) begin
                i_ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            got.new_src           = o_new_src_addr;
            got.new_dst           = o_new_dst_addr;
            got.changed           = o_tuple_changed;
            got.private_or_subnet = o_private_or_on_subnet;
            got.is_iface          = o_is_interface_addr;
            got.status            = o_status;
            chk.check_reply(got);
            taken++;
        end
    end

    // Stimulus: directed corners first, then random table phases.
    initial begin : stimulus
        t_request    rq;
        int unsigned n_fill;
        int unsigned n_query;
        int unsigned r;

        chk             = new();
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_ready         = 1'b0;
        i_opcode        = OP_CLEAR;
        i_entry_address = 32'h0;
        i_entry_netmask = 32'h0;
        i_src_addr      = 32'h0;
        i_dst_addr      = 32'h0;
        i_src_port      = 16'h0;
        i_dst_port      = 16'h0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty table: both addresses zero, with equal and then unequal ports
        rq = base_request(OP_CLEAR);
        send_request(rq);
        rq = base_request(OP_RESOLVE);
        rq.src_addr = 32'h0;
        rq.dst_addr = 32'h0;
        rq.src_port = 16'hffff;
        rq.dst_port = 16'hffff;
        send_request(rq);
        rq.src_port = 16'h0000;
        send_request(rq);

        // private blocks and the edges of 172.16/12
        rq = base_request(OP_CLASSIFY);
        rq.dst_addr = ip(10, 255, 255, 255);
        send_request(rq);
        rq.dst_addr = ip(172, 31, 255, 255);
        send_request(rq);
        rq.dst_addr = ip(172, 32, 0, 0);
        send_request(rq);
        rq.dst_addr = ip(192, 168, 0, 1);
        send_request(rq);

        // loopback only: no usable fill, a zero gets written
        rq = base_request(OP_APPEND);
        rq.entry_address = LOOPBACK;
        rq.entry_netmask = ip(255, 0, 0, 0);
        send_request(rq);
        rq = base_request(OP_RESOLVE);
        rq.src_addr = 32'h0;
        rq.dst_addr = ip(8, 8, 8, 8);
        rq.src_port = 16'd1;
        rq.dst_port = 16'd2;
        send_request(rq);

        // one real interface: subnet fill, exact fill skipped and taken
        rq = base_request(OP_APPEND);
        rq.entry_address = ip(192, 168, 1, 10);
        rq.entry_netmask = ip(255, 255, 255, 0);
        send_request(rq);
        rq = base_request(OP_RESOLVE);
        rq.src_addr = 32'h0;
        rq.dst_addr = ip(192, 168, 1, 77);
        send_request(rq);
        rq.src_addr = ip(192, 168, 1, 10);
        rq.dst_addr = 32'h0;
        rq.src_port = 16'd80;
        rq.dst_port = 16'd80;
        send_request(rq);
        rq.dst_port = 16'd443;
        send_request(rq);
        rq.dst_addr = ip(8, 8, 8, 8);
        send_request(rq);
        rq = base_request(OP_CLASSIFY);
        rq.dst_addr = ip(192, 168, 1, 10);
        send_request(rq);

        // fill the table, including all-zero and all-one entries, then overflow
        for (int i = 0; i < 15; i++) begin
            rq = base_request(OP_APPEND);
            rq.entry_address = (i == 0) ? 32'h0 : (i == 1) ? 32'hffff_ffff : ip(100 + i, i, 0, 1);
            rq.entry_netmask = (i == 0) ? 32'h0 : (i == 1) ? 32'hffff_ffff : ip(255, 255, 0, 0);
            send_request(rq);
        end
        rq = base_request(OP_RESOLVE);
        rq.src_addr = 32'h0;
        rq.dst_addr = ip(9, 9, 9, 9);
        send_request(rq);

        // random phases: usually clear, fill to some depth, then query
        while (n_sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 4) != 0) send_request(make_request(OP_CLEAR));
            n_fill = ($urandom_range(0, 3) == 0) ? $urandom_range(14, 19) : $urandom_range(0, 5);
            repeat (n_fill) send_request(make_request(OP_APPEND));
            n_query = $urandom_range(8, 30);
            repeat (n_query) begin
                r = $urandom_range(0, 19);
                if (r == 0)
                    send_request(make_request(t_opcode'($urandom_range(0, 3))));
                else if (r < 3)
                    send_request(make_request(OP_APPEND));
                else if (r < 12)
                    send_request(make_request(OP_RESOLVE));
                else
                    send_request(make_request(OP_CLASSIFY));
            end
        end
        i_valid <= 1'b0;

        // drain, then give a stray extra word the chance to show up
        while (chk.pending_replies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (chk.n_errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
